>>> rtl/tcw_pkg.sv
// shared constants and types for the text console character writer
`default_nettype none

package tcw_pkg;

  // grid geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int IDX_W      = $clog2(CELL_COUNT);
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int CELL_W     = 16;

  // first cell of the bottom row
  localparam logic [IDX_W-1:0] LAST_BASE = IDX_W'((ROWS - 1) * COLUMNS);

  // operation codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // character codes
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  // attribute and cell after reset
  localparam logic [7:0]        ATTR_RESET = 8'h07;
  localparam logic [CELL_W-1:0] CELL_RESET = {ATTR_RESET, CH_SPACE};

  // request to the shared address adder
  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic             sub;
  } addr_op_t;

endpackage

`default_nettype wire

>>> rtl/tcw_ram.sv
// single write port, single registered read port cell memory
`default_nettype none

module tcw_ram #(
  parameter int DEPTH = 2000,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/tcw_addr_unit.sv
// shared cell address adder used by the execute and newline steps of the sequencer
`default_nettype none

module tcw_addr_unit import tcw_pkg::*; (
  input  wire addr_op_t         op_i,
  output logic      [IDX_W-1:0] sum_o
);

  // add or subtract on the linear cell index
  always_comb begin
    if (op_i.sub) begin
      sum_o = op_i.a - op_i.b;
    end else begin
      sum_o = op_i.a + op_i.b;
    end
  end

endmodule

`default_nettype wire

>>> rtl/text_console_char_writer.sv
// text console character writer: cursor sequencer, cell memory and scroll engine
//
//   channel  direction  handshake                     word
//   in       input      in_valid_i / in_stall_o       operation, char_code, read_row, read_col
//   out      output     out_valid_o / out_stall_i     cursor_col, cursor_row, cursor_index,
//                                                     cell_value
//   cfg      input      cfg_we_i                      attribute
//
// a printed character, backspace or out-of-range read passes through accept, execute and
// result; a newline or an in-range read adds one step between execute and result, all through
// the one address adder and the one cell memory. an item that scrolls runs a row-shift copy at
// one cell per cycle, then blanks the bottom row. after reset a clearing pass writes every cell
// before the first word is taken. a result is held while out_stall_i is high; no new word is
// taken until it leaves.
`default_nettype none

module text_console_char_writer import tcw_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [7:0]        cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              operation_i,
  input  wire logic [7:0]        char_code_i,
  input  wire logic [ROW_W-1:0]  read_row_i,
  input  wire logic [COL_W-1:0]  read_col_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [COL_W-1:0]  cursor_col_o,
  output logic      [ROW_W-1:0]  cursor_row_o,
  output logic      [IDX_W-1:0]  cursor_index_o,
  output logic      [CELL_W-1:0] cell_value_o
);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_NL    = 3'd3;
  localparam logic [2:0] S_RDATA = 3'd4;
  localparam logic [2:0] S_COPY  = 3'd5;
  localparam logic [2:0] S_BLANK = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(CELL_COUNT - 1);
  localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);

  logic [2:0]        state_q, state_d;
  logic [7:0]        attr_q;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  src_q, src_d;
  logic [IDX_W-1:0]  dst_q, dst_d;
  logic              src_done_q, src_done_d;
  logic              pend_q, pend_d;

  logic              op_q;
  logic [7:0]        ch_q;
  logic [ROW_W-1:0]  rd_row_q;
  logic [COL_W-1:0]  rd_col_q;
  logic [CELL_W-1:0] cell_q, cell_d;

  addr_op_t          aop;
  logic [IDX_W-1:0]  asum;

  logic              ram_we, ram_re, issue;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;
  logic              rd_in_range;

  tcw_addr_unit u_addr (
    .op_i  (aop),
    .sum_o (asum)
  );

  tcw_ram #(
    .DEPTH (CELL_COUNT),
    .WIDTH (CELL_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_in_range = (rd_row_q < LAST_ROW + ROW_W'(1)) && (rd_col_q < LAST_COL + COL_W'(1));

  // attribute register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  // sequencer next state and datapath control
  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    row_d      = row_q;
    idx_d      = idx_q;
    src_d      = src_q;
    dst_d      = dst_q;
    src_done_d = src_done_q;
    pend_d     = 1'b0;
    cell_d     = cell_q;
    aop.a      = idx_q;
    aop.b      = IDX_W'(1);
    aop.sub    = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = dst_q;
    ram_wdata  = {attr_q, CH_SPACE};
    ram_re     = 1'b0;
    ram_raddr  = src_q;
    issue      = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = CELL_RESET;
        dst_d     = dst_q + IDX_W'(1);
        if (dst_q == LAST_CELL) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cell_d  = '0;
        state_d = S_OUT;
        if (op_q == OP_READ) begin
          // read: row base times columns plus column
          aop.a = IDX_W'(rd_row_q) * IDX_W'(COLUMNS);
          aop.b = IDX_W'(rd_col_q);
          if (rd_in_range) begin
            ram_re    = 1'b1;
            ram_raddr = asum;
            state_d   = S_RDATA;
          end
        end else begin
          case (ch_q)
            CH_NEWLINE: begin
              col_d = '0;
              if (row_q == LAST_ROW) begin
                idx_d      = LAST_BASE;
                src_d      = IDX_W'(COLUMNS);
                dst_d      = '0;
                src_done_d = 1'b0;
                state_d    = S_COPY;
              end else begin
                // back to the row start, the next step adds one row
                aop.b   = IDX_W'(col_q);
                aop.sub = 1'b1;
                idx_d   = asum;
                state_d = S_NL;
              end
            end
            CH_BACKSPACE: begin
              if (col_q != '0) begin
                aop.sub   = 1'b1;
                idx_d     = asum;
                col_d     = col_q - COL_W'(1);
                ram_we    = 1'b1;
                ram_waddr = asum;
                ram_wdata = {attr_q, CH_SPACE};
              end
            end
            default: begin
              // printed character, then advance with wrap
              ram_we    = 1'b1;
              ram_waddr = idx_q;
              ram_wdata = {attr_q, ch_q};
              idx_d     = asum;
              if (col_q == LAST_COL) begin
                col_d = '0;
                if (row_q == LAST_ROW) begin
                  idx_d      = LAST_BASE;
                  src_d      = IDX_W'(COLUMNS);
                  dst_d      = '0;
                  src_done_d = 1'b0;
                  state_d    = S_COPY;
                end else begin
                  row_d = row_q + ROW_W'(1);
                end
              end else begin
                col_d = col_q + COL_W'(1);
              end
            end
          endcase
        end
      end
      S_NL: begin
        aop.b   = IDX_W'(COLUMNS);
        idx_d   = asum;
        row_d   = row_q + ROW_W'(1);
        state_d = S_OUT;
      end
      S_RDATA: begin
        cell_d  = ram_rdata;
        state_d = S_OUT;
      end
      S_COPY: begin
        // read one row down, write it back a row up on the next cycle
        issue     = !src_done_q;
        ram_re    = issue;
        ram_raddr = src_q;
        pend_d    = issue;
        if (issue) begin
          src_d = src_q + IDX_W'(1);
          if (src_q == LAST_CELL) begin
            src_done_d = 1'b1;
          end
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = dst_q;
          ram_wdata = ram_rdata;
          dst_d     = dst_q + IDX_W'(1);
        end
        if (src_done_q && pend_q) begin
          state_d = S_BLANK;
        end
      end
      S_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = dst_q;
        ram_wdata = {attr_q, CH_SPACE};
        dst_d     = dst_q + IDX_W'(1);
        if (dst_q == LAST_CELL) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and cursor registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      col_q      <= '0;
      row_q      <= '0;
      idx_q      <= '0;
      src_q      <= '0;
      dst_q      <= '0;
      src_done_q <= 1'b0;
      pend_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      col_q      <= col_d;
      row_q      <= row_d;
      idx_q      <= idx_d;
      src_q      <= src_d;
      dst_q      <= dst_d;
      src_done_q <= src_done_d;
      pend_q     <= pend_d;
    end
  end

  // input word capture and result cell
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      op_q     <= operation_i;
      ch_q     <= char_code_i;
      rd_row_q <= read_row_i;
      rd_col_q <= read_col_i;
    end
    cell_q <= cell_d;
  end

  // ports
  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = (state_q == S_OUT);
  assign cursor_col_o   = col_q;
  assign cursor_row_o   = row_q;
  assign cursor_index_o = idx_q;
  assign cell_value_o   = cell_q;

  // linear index tracks row and column on every result
  a_idx_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (int'(cursor_index_o) == int'(cursor_row_o) * COLUMNS + int'(cursor_col_o)))
    else $error("cursor index does not match row and column");

  // cursor never leaves the grid
  a_cursor_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(col_q) < COLUMNS) && (int'(row_q) < ROWS))
    else $error("cursor outside the grid");

  // never taking a word while a result is pending
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("ready for input while a result is pending");

  // a scroll always leaves the cursor at the start of the bottom row
  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BLANK) |-> (row_q == LAST_ROW && col_q == '0 && idx_q == LAST_BASE))
    else $error("cursor wrong during scroll");

endmodule

`default_nettype wire
